FILE: hw/rtl/cycle_stepped_cpu_core_subset_top_defines.svh
// Assertion macros for the checker file of the CPU core subset.
// No dependencies; take in with `include before use.
`ifndef CYCLE_STEPPED_CPU_CORE_SUBSET_TOP_DEFINES_SVH
`define CYCLE_STEPPED_CPU_CORE_SUBSET_TOP_DEFINES_SVH

// Concurrent check on the rising clock, off while reset is low.
`define CSC_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) prop) else $error(msg);

// Same check with the core's usual clock and reset names.
`define CSC_ASSERT(lbl, prop, msg) \
    `CSC_ASSERT_CLK(lbl, i_clk, i_rst_n, prop, msg)

`endif

FILE: hw/rtl/csc_pkg.sv
// Types and constants of the cycle-stepped CPU core subset.
// No dependencies; used by csc_step and the top level.
package csc_pkg;

    localparam int unsigned IN_W  = 8;
    localparam int unsigned OUT_W = 72;

    localparam logic [7:0] OP_LDA = 8'hA9;
    localparam logic [7:0] OP_LDX = 8'hA2;
    localparam logic [7:0] OP_LDY = 8'hA0;
    localparam logic [7:0] OP_SBC = 8'hE9;
    localparam logic [7:0] OP_STA = 8'h9D;
    localparam logic [7:0] OP_BEQ = 8'hF0;
    localparam logic [7:0] OP_DEX = 8'hCA;
    localparam logic [7:0] OP_JMP = 8'h4C;

    localparam logic [15:0] VEC_RESET_LO = 16'hFFFC;
    localparam logic [15:0] VEC_RESET_HI = 16'hFFFD;
    localparam logic [7:0]  SIGN_BIT     = 8'b1000_0000;

    localparam int unsigned FL_C = 0;
    localparam int unsigned FL_Z = 1;
    localparam int unsigned FL_V = 2;
    localparam int unsigned FL_N = 3;

    localparam logic [1:0] CYC_FETCH = 2'd0;
    localparam logic [1:0] CYC_ONE   = 2'd1;
    localparam logic [1:0] CYC_TWO   = 2'd2;
    localparam logic [1:0] CYC_THREE = 2'd3;

    // What the data of the next cycle answers.
    typedef enum logic [2:0] {
        PEND_NONE   = 3'd0,
        PEND_VEC_LO = 3'd1,
        PEND_VEC_HI = 3'd2,
        PEND_OPCODE = 3'd3,
        PEND_IMM    = 3'd4,
        PEND_LOW    = 3'd5,
        PEND_HIGH   = 3'd6
    } t_pend;

    typedef struct packed {
        logic [15:0] pc;
        logic [7:0]  acc;
        logic [7:0]  x;
        logic [7:0]  y;
        logic [3:0]  flags;
        logic [7:0]  opcode;
        logic [1:0]  cyc;
        logic [7:0]  opl;
        logic [7:0]  oph;
        t_pend       pend;
        logic        in_reset;
    } t_cpu_state;

    typedef struct packed {
        logic [15:0] addr;
        logic        valid;
        logic        write;
        logic [7:0]  wdata;
        logic        fetch;
    } t_bus;

    localparam t_cpu_state CPU_RESET = '{
        pc: 16'd0, acc: 8'd0, x: 8'd0, y: 8'd0, flags: 4'd0, opcode: 8'd0,
        cyc: CYC_ONE, opl: 8'd0, oph: 8'd0, pend: PEND_NONE, in_reset: 1'b1
    };

    function automatic logic [3:0] set_zn(input logic [3:0] f, input logic [7:0] v);
        logic [3:0] r;
        r       = f;
        r[FL_Z] = (v == 8'd0);
        r[FL_N] = v[7];
        return r;
    endfunction

endpackage

FILE: hw/rtl/cycle_stepped_cpu_core_subset_top.sv
// Top level of the cycle-stepped CPU core subset: input register, step logic,
// architectural state and result register. Depends on csc_pkg and csc_step.
//
//  channel   | dir | tdata fields, lowest bit first
//  s_axis    | in  | read_data[7:0]
//  m_axis    | out | bus_address, bus_valid, bus_write, write_data, opcode_fetch,
//            |     | acc_value, x_value, y_value, flag_bits, pc_value, pad bit
//
// One request per clock while results are taken; input and result are both registered.
// The whole bus cycle is worked out between the input register and the result
// register, so a new request enters every cycle while the result side takes them.
// Reset (i_rst_n low, synchronous) clears both valid bits and puts the core at the
// start of the reset vector read. A stalled result holds; once the input register
// is also full, s_axis_tready drops.
module cycle_stepped_cpu_core_subset_top (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [csc_pkg::IN_W-1:0]  s_axis_tdata,   // read_data[7:0]
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // bus_address[15:0], bus_valid[16], bus_write[17], write_data[25:18],
    // opcode_fetch[26], acc_value[34:27], x_value[42:35], y_value[50:43],
    // flag_bits[54:51], pc_value[70:55], zero[71]
    output logic [csc_pkg::OUT_W-1:0] m_axis_tdata
);
    import csc_pkg::*;

    logic             r_in_valid;
    logic [7:0]       r_in_data;
    logic             r_out_valid;
    logic [OUT_W-1:0] r_out_data;
    t_cpu_state       r_state;
    t_cpu_state       n_state;
    t_bus             step_bus;
    logic             advance;

    csc_step u_step (
        .i_state (r_state),
        .i_data  (r_in_data),
        .o_state (n_state),
        .o_bus   (step_bus)
    );

    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= CPU_RESET;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers; no reset needed.
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_data <= s_axis_tdata;
        end
        if (advance) begin
            r_out_data <= {1'b0, n_state.pc, n_state.flags, n_state.y, n_state.x,
                           n_state.acc, step_bus.fetch, step_bus.wdata,
                           step_bus.write, step_bus.valid, step_bus.addr};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

FILE: hw/rtl/csc_step.sv
// One bus cycle of the CPU core: take in the returned byte, then drive this cycle.
// Depends on csc_pkg.
module csc_step (
    input  csc_pkg::t_cpu_state i_state,
    input  logic [7:0]          i_data,
    output csc_pkg::t_cpu_state o_state,
    output csc_pkg::t_bus       o_bus
);
    import csc_pkg::*;

    t_cpu_state st;
    t_bus       bus;
    logic [8:0] sbc_sum;
    logic [7:0] sbc_res;
    logic [3:0] sbc_fl;
    logic [15:0] base;

    always_comb begin
        st = i_state;
        // Latch the byte answering last cycle's read.
        unique case (i_state.pend)
            PEND_VEC_LO: st.opl = i_data;
            PEND_VEC_HI: st.pc = {i_data, i_state.opl};
            PEND_OPCODE: st.opcode = i_data;
            PEND_IMM: begin
                st.opl = i_data;
                case (i_state.opcode)
                    OP_LDA: begin st.acc = i_data; st.flags = set_zn(st.flags, i_data); end
                    OP_LDX: begin st.x = i_data; st.flags = set_zn(st.flags, i_data); end
                    OP_LDY: begin st.y = i_data; st.flags = set_zn(st.flags, i_data); end
                    default: ;
                endcase
            end
            PEND_LOW:  st.opl = i_data;
            PEND_HIGH: st.oph = i_data;
            default: ;
        endcase
        st.pend = PEND_NONE;

        sbc_sum = {1'b0, st.acc} + {1'b0, ~st.opl} + {8'd0, st.flags[FL_C]};
        sbc_res = sbc_sum[7:0];
        sbc_fl  = st.flags;
        sbc_fl[FL_C] = sbc_sum[8];
        sbc_fl[FL_V] = ((st.acc ^ st.opl) & (st.acc ^ sbc_res) & SIGN_BIT) != 8'd0;
        sbc_fl  = set_zn(sbc_fl, sbc_res);
        base    = {st.oph, st.opl};

        bus = '0;
        if (st.in_reset) begin
            bus.valid = 1'b1;
            if (st.cyc == CYC_ONE) begin
                bus.addr = VEC_RESET_LO;
                st.pend  = PEND_VEC_LO;
                st.cyc   = CYC_TWO;
            end else begin
                bus.addr    = VEC_RESET_HI;
                st.pend     = PEND_VEC_HI;
                st.cyc      = CYC_FETCH;
                st.in_reset = 1'b0;
            end
        end else begin
            unique case (st.cyc)
                CYC_FETCH: begin
                    bus.addr  = st.pc;
                    bus.valid = 1'b1;
                    bus.fetch = 1'b1;
                    st.pc     = st.pc + 16'd1;
                    st.pend   = PEND_OPCODE;
                    st.cyc    = CYC_ONE;
                end
                CYC_ONE: begin
                    st.cyc = CYC_FETCH;
                    case (st.opcode) inside
                        OP_LDA, OP_LDX, OP_LDY, OP_SBC, OP_BEQ: begin
                            bus.addr  = st.pc;
                            bus.valid = 1'b1;
                            st.pc     = st.pc + 16'd1;
                            st.pend   = PEND_IMM;
                            if (st.opcode == OP_SBC || st.opcode == OP_BEQ) begin
                                st.cyc = CYC_TWO;
                            end
                        end
                        OP_STA, OP_JMP: begin
                            bus.addr  = st.pc;
                            bus.valid = 1'b1;
                            st.pc     = st.pc + 16'd1;
                            st.pend   = PEND_LOW;
                            st.cyc    = CYC_TWO;
                        end
                        OP_DEX: begin
                            st.x     = st.x - 8'd1;
                            st.flags = set_zn(st.flags, st.x);
                        end
                        default: ;
                    endcase
                end
                CYC_TWO: begin
                    st.cyc = CYC_FETCH;
                    case (st.opcode) inside
                        OP_SBC: begin
                            st.acc   = sbc_res;
                            st.flags = sbc_fl;
                        end
                        OP_BEQ: begin
                            if (st.flags[FL_Z]) begin
                                st.pc = st.pc + {{8{st.opl[7]}}, st.opl};
                            end
                        end
                        OP_STA, OP_JMP: begin
                            bus.addr  = st.pc;
                            bus.valid = 1'b1;
                            st.pc     = st.pc + 16'd1;
                            st.pend   = PEND_HIGH;
                            st.cyc    = CYC_THREE;
                        end
                        default: ;
                    endcase
                end
                default: begin
                    st.cyc = CYC_FETCH;
                    if (st.opcode == OP_STA) begin
                        bus.addr  = base + {8'd0, st.x};
                        bus.valid = 1'b1;
                        bus.write = 1'b1;
                        bus.wdata = st.acc;
                    end else if (st.opcode == OP_JMP) begin
                        st.pc = base;
                    end
                end
            endcase
        end
    end

    assign o_state = st;
    assign o_bus   = bus;

endmodule

FILE: hw/rtl/csc_checker.sv
// Port-level checks on the CPU core subset, bound to the top level.
// Depends on csc_pkg and the assertion macros header.
`include "cycle_stepped_cpu_core_subset_top_defines.svh"

module csc_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      s_axis_tvalid,
    input logic                      s_axis_tready,
    input logic                      m_axis_tvalid,
    input logic                      m_axis_tready,
    input logic [csc_pkg::OUT_W-1:0] m_axis_tdata
);
    import csc_pkg::*;

    logic        in_seen;
    logic        res_vld;
    logic        out_stall;
    logic        res_access;
    logic        res_write;
    logic        res_fetch;
    logic        res_quiet;
    logic [15:0] res_addr;
    logic [7:0]  res_wdata;

    assign in_seen    = s_axis_tvalid && s_axis_tready;
    assign res_vld    = m_axis_tvalid;
    assign out_stall  = m_axis_tvalid && !m_axis_tready;
    assign res_addr   = m_axis_tdata[15:0];
    assign res_access = m_axis_tdata[16];
    assign res_write  = m_axis_tdata[17];
    assign res_wdata  = m_axis_tdata[25:18];
    assign res_fetch  = m_axis_tdata[26];
    assign res_quiet  = (res_addr == 16'd0) && (res_wdata == 8'd0) && !res_write;

    `CSC_ASSERT(a_write_is_access, (res_vld && res_write) |-> res_access, "write without access")
    `CSC_ASSERT(a_fetch_is_read, (res_vld && res_fetch) |-> (res_access && !res_write), "bad fetch")
    `CSC_ASSERT(a_idle_bus_quiet, (res_vld && !res_access) |-> res_quiet, "idle cycle drives bus")
    `CSC_ASSERT(a_out_hold, out_stall |=> (res_vld && $stable(m_axis_tdata)), "held result changed")
    `CSC_ASSERT(a_in_to_out, (in_seen && !res_vld) |=> ##1 res_vld, "request made no result")

endmodule

bind cycle_stepped_cpu_core_subset_top csc_checker u_csc_checker (.*);

FILE: verif/tb.sv
// Testbench of the cycle-stepped CPU core subset: a scoreboard steps its own copy of the core
// per request, serves program bytes to match each bus read, and checks every result field.
// Depends on csc_pkg and cycle_stepped_cpu_core_subset_top.
module tb;
    import csc_pkg::*;

    localparam int TOTAL_REQUESTS = 1730;
    localparam int CALM_REQUESTS  = 200;
    localparam int LONG_HOLD_AT   = 600;
    localparam int LONG_HOLD_LEN  = 300;
    localparam int DRAIN_CYCLES   = 10;
    localparam int LIMIT_CYCLES   = 400000;

    // Result layout, highest bit first.
    typedef struct packed {
        logic        zero_pad;
        logic [15:0] pc;
        logic [3:0]  flags;
        logic [7:0]  y;
        logic [7:0]  x;
        logic [7:0]  acc;
        logic        fetch;
        logic [7:0]  wdata;
        logic        write;
        logic        valid;
        logic [15:0] addr;
    } t_cycle_result;

    class core_cycle_scoreboard;
        t_cpu_state    cpu;
        t_cycle_result expected_cycles[$];
        int unsigned   mismatches;

        function new();
            cpu        = CPU_RESET;
            mismatches = 0;
        endfunction

        function void apply_zero_negative(logic [7:0] v);
            cpu.flags[FL_Z] = (v == 8'd0);
            cpu.flags[FL_N] = v[7];
        endfunction

        // Step the core by one bus cycle for an accepted request.
        function void note_request(logic [7:0] data);
            t_cycle_result r;
            logic [7:0]    op;
            logic [1:0]    nxt;
            logic [8:0]    sum;
            logic [7:0]    diff;
            r = '0;
            case (cpu.pend)
                PEND_VEC_LO: cpu.opl = data;
                PEND_VEC_HI: cpu.pc = {data, cpu.opl};
                PEND_OPCODE: cpu.opcode = data;
                PEND_IMM: begin
                    cpu.opl = data;
                    case (cpu.opcode)
                        OP_LDA: begin
                            cpu.acc = data;
                            apply_zero_negative(data);
                        end
                        OP_LDX: begin
                            cpu.x = data;
                            apply_zero_negative(data);
                        end
                        OP_LDY: begin
                            cpu.y = data;
                            apply_zero_negative(data);
                        end
                        default: ;
                    endcase
                end
                PEND_LOW:  cpu.opl = data;
                PEND_HIGH: cpu.oph = data;
                default: ;
            endcase
            cpu.pend = PEND_NONE;
            op  = cpu.opcode;
            nxt = CYC_FETCH;

            if (cpu.in_reset) begin
                r.valid = 1'b1;
                if (cpu.cyc == CYC_ONE) begin
                    r.addr   = VEC_RESET_LO;
                    cpu.pend = PEND_VEC_LO;
                    nxt      = CYC_TWO;
                end else begin
                    r.addr       = VEC_RESET_HI;
                    cpu.pend     = PEND_VEC_HI;
                    cpu.in_reset = 1'b0;
                end
            end else begin
                case (cpu.cyc)
                    CYC_FETCH: begin
                        r.addr   = cpu.pc;
                        cpu.pc   = cpu.pc + 16'd1;
                        r.valid  = 1'b1;
                        r.fetch  = 1'b1;
                        cpu.pend = PEND_OPCODE;
                        nxt      = CYC_ONE;
                    end
                    CYC_ONE: begin
                        case (op)
                            OP_LDA, OP_LDX, OP_LDY, OP_SBC, OP_BEQ: begin
                                r.addr   = cpu.pc;
                                cpu.pc   = cpu.pc + 16'd1;
                                r.valid  = 1'b1;
                                cpu.pend = PEND_IMM;
                                nxt = (op == OP_SBC || op == OP_BEQ) ? CYC_TWO : CYC_FETCH;
                            end
                            OP_STA, OP_JMP: begin
                                r.addr   = cpu.pc;
                                cpu.pc   = cpu.pc + 16'd1;
                                r.valid  = 1'b1;
                                cpu.pend = PEND_LOW;
                                nxt      = CYC_TWO;
                            end
                            OP_DEX: begin
                                cpu.x = cpu.x - 8'd1;
                                apply_zero_negative(cpu.x);
                            end
                            default: ;
                        endcase
                    end
                    CYC_TWO: begin
                        case (op)
                            OP_SBC: begin
                                sum  = {1'b0, cpu.acc} + {1'b0, ~cpu.opl}
                                     + {8'd0, cpu.flags[FL_C]};
                                diff = sum[7:0];
                                cpu.flags[FL_C] = sum[8];
                                cpu.flags[FL_V] =
                                    (((cpu.acc ^ cpu.opl) & (cpu.acc ^ diff) & SIGN_BIT) != 0);
                                cpu.acc = diff;
                                apply_zero_negative(diff);
                            end
                            OP_BEQ: begin
                                if (cpu.flags[FL_Z])
                                    cpu.pc = cpu.pc + {{8{cpu.opl[7]}}, cpu.opl};
                            end
                            OP_STA, OP_JMP: begin
                                r.addr   = cpu.pc;
                                cpu.pc   = cpu.pc + 16'd1;
                                r.valid  = 1'b1;
                                cpu.pend = PEND_HIGH;
                                nxt      = CYC_THREE;
                            end
                            default: ;
                        endcase
                    end
                    default: begin
                        if (op == OP_STA) begin
                            r.addr  = {cpu.oph, cpu.opl} + {8'd0, cpu.x};
                            r.valid = 1'b1;
                            r.write = 1'b1;
                            r.wdata = cpu.acc;
                        end else if (op == OP_JMP) begin
                            cpu.pc = {cpu.oph, cpu.opl};
                        end
                    end
                endcase
            end
            cpu.cyc = nxt;

            r.acc   = cpu.acc;
            r.x     = cpu.x;
            r.y     = cpu.y;
            r.flags = cpu.flags;
            r.pc    = cpu.pc;
            expected_cycles.push_back(r);
        endfunction

        function void compare_field(string field, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                $error("%s mismatch: expected %0h, actual %0h", field, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(logic [OUT_W-1:0] raw);
            t_cycle_result got;
            t_cycle_result want;
            got = t_cycle_result'(raw);
            if (expected_cycles.size() == 0) begin
                $error("result %h arrived with no request outstanding", raw);
                mismatches++;
                return;
            end
            want = expected_cycles.pop_front();
            compare_field("bus_address", want.addr, got.addr);
            compare_field("bus_valid", want.valid, got.valid);
            compare_field("bus_write", want.write, got.write);
            compare_field("write_data", want.wdata, got.wdata);
            compare_field("opcode_fetch", want.fetch, got.fetch);
            compare_field("acc_value", want.acc, got.acc);
            compare_field("x_value", want.x, got.x);
            compare_field("y_value", want.y, got.y);
            compare_field("flag_bits", want.flags, got.flags);
            compare_field("pc_value", want.pc, got.pc);
            compare_field("zero_pad", want.zero_pad, got.zero_pad);
        endfunction
    endclass

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [IN_W-1:0]   s_axis_tdata  = '0;   // read_data[7:0]
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [OUT_W-1:0]  m_axis_tdata;         // bus_address .. pc_value, zero pad (see t_cycle_result)

    core_cycle_scoreboard cpu_sb;
    logic [7:0]           boot_program[$];
    int                   requests_sent = 0;
    int                   cycle_count   = 0;

    cycle_stepped_cpu_core_subset_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Answer the pending bus read: boot program first, then random programs.
    function automatic logic [7:0] pick_byte(t_pend want);
        int roll;
        roll = $urandom_range(0, 99);
        if (want != PEND_NONE && boot_program.size() != 0)
            return boot_program.pop_front();
        if (want == PEND_NONE || roll < 3)
            return 8'($urandom_range(0, 255));
        if (want == PEND_OPCODE) begin
            if (roll < 90) begin
                case ($urandom_range(0, 7))
                    0: return OP_LDA;
                    1: return OP_LDX;
                    2: return OP_LDY;
                    3: return OP_SBC;
                    4: return OP_STA;
                    5: return OP_BEQ;
                    6: return OP_DEX;
                    default: return OP_JMP;
                endcase
            end
            return 8'($urandom_range(0, 255));
        end
        // operand bytes lean on values that flip Z, N, C and V
        if (roll < 23) return 8'h00;
        if (roll < 33) return 8'hFF;
        if (roll < 41) return 8'h80;
        if (roll < 49) return 8'h7F;
        if (roll < 53) return 8'h01;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic drive_requests();
        int idle_left;
        bit taken;
        bit done;
        idle_left = 0;
        done      = 1'b0;
        while (!done) begin
            @(posedge i_clk);
            taken = s_axis_tvalid && s_axis_tready;
            if (taken) begin
                cpu_sb.note_request(s_axis_tdata);
                requests_sent++;
            end
            if (s_axis_tvalid && !taken) begin
                // hold the offered request
            end else if (requests_sent >= TOTAL_REQUESTS) begin
                s_axis_tvalid <= 1'b0;
                done = 1'b1;
            end else if (idle_left > 0) begin
                idle_left--;
                s_axis_tvalid <= 1'b0;
            end else if (requests_sent < TOTAL_REQUESTS - CALM_REQUESTS &&
                         $urandom_range(0, 99) < 6) begin
                idle_left = $urandom_range(1, 15) - 1;
                s_axis_tvalid <= 1'b0;
            end else begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= pick_byte(cpu_sb.cpu.pend);
            end
        end
    endtask

    task automatic drive_result_ready();
        int  stall_left;
        bit  held_long;
        stall_left = 0;
        held_long  = 1'b0;
        forever begin
            @(posedge i_clk);
            if (!held_long && requests_sent >= LONG_HOLD_AT) begin
                // stall long enough for the core to back up its input
                held_long = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD_LEN) @(posedge i_clk);
            end else if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else if (requests_sent < TOTAL_REQUESTS - CALM_REQUESTS &&
                         $urandom_range(0, 99) < 8) begin
                stall_left = $urandom_range(1, 15) - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            cpu_sb.check_result(m_axis_tdata);
    end

    initial begin
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        cpu_sb = new();
        // reset vector FFFE, then a short program crossing the top of memory
        boot_program = '{8'hFE, 8'hFF,
                         OP_LDA, 8'h00,
                         OP_BEQ, 8'h80,
                         OP_LDX, 8'h00,
                         OP_DEX,
                         OP_LDA, 8'h80,
                         OP_SBC, 8'h01,
                         OP_LDY, 8'hFF,
                         OP_BEQ, 8'h05,
                         OP_STA, 8'hFF, 8'hFF,
                         OP_JMP, 8'h34, 8'h12,
                         8'h02};
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        fork
            drive_result_ready();
        join_none
        drive_requests();
        while (cpu_sb.expected_cycles.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (cpu_sb.mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
